// ===== sv/bmp_header_checker_assert.svh =====
// Assertion macros used by the bitmap header checker's port-level checker.
`ifndef BMP_HEADER_CHECKER_ASSERT_SVH
`define BMP_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMPHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp header checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMPHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp header checker assertion failed");

`endif

// ===== sv/bmphc_pkg.sv =====
// Types and constants for the bitmap header checker.
`timescale 1ns / 1ps
`default_nettype none

package bmphc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status_code;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] bmp_size;
  } out_item_t;

  // Header fields that the front end hands to the back end once complete.
  typedef enum logic [3:0] {
    FLD_SIGNATURE,
    FLD_FILE_SIZE,
    FLD_RESERVED,
    FLD_OFFSET,
    FLD_INFO_SIZE,
    FLD_WIDTH,
    FLD_HEIGHT,
    FLD_PLANES,
    FLD_BPP,
    FLD_COMPRESSION,
    FLD_IMAGE_SIZE
  } field_t;

  typedef struct packed {
    field_t      field;
    logic [31:0] value;
  } field_entry_t;

  // Status codes, in the order the checks are made.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SIGNATURE   = 4'd1;
  localparam logic [3:0] ST_FILE_SIZE   = 4'd2;
  localparam logic [3:0] ST_RESERVED    = 4'd3;
  localparam logic [3:0] ST_OFFSET      = 4'd4;
  localparam logic [3:0] ST_INFO_SIZE   = 4'd5;
  localparam logic [3:0] ST_WIDTH       = 4'd6;
  localparam logic [3:0] ST_HEIGHT      = 4'd7;
  localparam logic [3:0] ST_PLANES      = 4'd8;
  localparam logic [3:0] ST_BPP         = 4'd9;
  localparam logic [3:0] ST_COMPRESSION = 4'd10;
  localparam logic [3:0] ST_IMAGE_SIZE  = 4'd11;
  localparam logic [3:0] ST_PRODUCT     = 4'd12;

  localparam logic [7:0]  SIG_FIRST    = 8'h42;
  localparam logic [7:0]  SIG_SECOND   = 8'h4D;
  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [31:0] INFO_BYTES   = 32'd40;
  localparam logic [31:0] PLANE_COUNT  = 32'd1;
  localparam logic [31:0] PIXEL_BITS   = 32'd24;
  localparam logic [31:0] PIXEL_BYTES  = 32'd3;

  // Byte offsets at which each field is complete.
  localparam logic [5:0] POS_SIG_END    = 6'd1;
  localparam logic [5:0] POS_SIZE_END   = 6'd5;
  localparam logic [5:0] POS_RSVD_END   = 6'd9;
  localparam logic [5:0] POS_OFFSET_END = 6'd13;
  localparam logic [5:0] POS_INFO_END   = 6'd17;
  localparam logic [5:0] POS_WIDTH_END  = 6'd21;
  localparam logic [5:0] POS_HEIGHT_END = 6'd25;
  localparam logic [5:0] POS_PLANES_END = 6'd27;
  localparam logic [5:0] POS_BPP_END    = 6'd29;
  localparam logic [5:0] POS_COMP_END   = 6'd33;
  localparam logic [5:0] POS_IMAGE_END  = 6'd37;
  localparam logic [5:0] POS_SHORT_LO   = 6'd26;
  localparam logic [5:0] POS_SHORT_HI   = 6'd30;

endpackage

`default_nettype wire

// ===== sv/bmp_header_checker.sv =====
// Bitmap header checker: 24 bpp uncompressed header validation, one byte per transaction.
// Throughput: one header byte per cycle; in_stall rises only when the field queue is full.
// The result follows the transaction carrying byte offset 37 through the field queue
// and then the back end's output register, which waits while a previous result is stalled.
// The 3 * width * height product runs in a two-stage multiplier fed by the stored fields.
// Reset: idle until a first-byte flag, queue empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module bmp_header_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  bmphc_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output bmphc_pkg::out_item_t out_data,
  input  wire                  out_stall
);
  import bmphc_pkg::*;

  logic         q_full;
  logic         push_valid;
  field_entry_t push_entry;
  logic         pop;
  logic         pop_valid;
  field_entry_t pop_entry;

  bmphc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  bmphc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  bmphc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

// ===== sv/bmphc_front.sv =====
// Front end: accepts header bytes, assembles little-endian fields and queues them.
`timescale 1ns / 1ps
`default_nettype none

module bmphc_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  bmphc_pkg::in_item_t     in_data,
  output logic                    in_stall,
  input  wire                     q_full,
  output logic                    push_valid,
  output bmphc_pkg::field_entry_t push_entry
);
  import bmphc_pkg::*;

  logic        done_r, done_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic        sig_r, sig_nxt;

  logic        accept;
  logic        active;
  logic [5:0]  pos;
  logic [1:0]  k;
  logic [7:0]  b;
  logic [31:0] value;
  logic        field_end;
  field_t      field;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign active   = in_data.first_byte || !done_r;
  assign pos      = in_data.first_byte ? 6'd0 : pos_r;
  assign b        = in_data.data_byte;

  always_comb begin
    // Two-byte fields sit at offsets 26 to 29, four-byte fields elsewhere.
    if (pos >= POS_SHORT_LO && pos < POS_SHORT_HI) begin
      k = {1'b0, pos[0]};
    end else begin
      k = pos[1:0] + 2'd2;
    end
    case (k)
      2'd0:    value = {24'd0, b};
      2'd1:    value = {16'd0, b, shift_r[7:0]};
      2'd2:    value = {8'd0, b, shift_r[15:0]};
      default: value = {b, shift_r};
    endcase
    if (pos == POS_SIG_END) begin
      value = {31'd0, sig_r && (b == SIG_SECOND)};
    end
  end

  always_comb begin
    field_end = 1'b1;
    case (pos)
      POS_SIG_END:    field = FLD_SIGNATURE;
      POS_SIZE_END:   field = FLD_FILE_SIZE;
      POS_RSVD_END:   field = FLD_RESERVED;
      POS_OFFSET_END: field = FLD_OFFSET;
      POS_INFO_END:   field = FLD_INFO_SIZE;
      POS_WIDTH_END:  field = FLD_WIDTH;
      POS_HEIGHT_END: field = FLD_HEIGHT;
      POS_PLANES_END: field = FLD_PLANES;
      POS_BPP_END:    field = FLD_BPP;
      POS_COMP_END:   field = FLD_COMPRESSION;
      POS_IMAGE_END:  field = FLD_IMAGE_SIZE;
      default: begin
        field     = FLD_SIGNATURE;
        field_end = 1'b0;
      end
    endcase
  end

  assign push_valid       = accept && active && field_end;
  assign push_entry.field = field;
  assign push_entry.value = value;

  always_comb begin
    done_nxt  = done_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    sig_nxt   = sig_r;
    if (accept && active) begin
      pos_nxt   = pos + 6'd1;
      shift_nxt = value[23:0];
      done_nxt  = (pos == POS_IMAGE_END);
      if (pos == 6'd0) begin
        sig_nxt = (b == SIG_FIRST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      pos_r  <= 6'd0;
    end else begin
      done_r <= done_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    sig_r   <= sig_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/bmphc_queue.sv =====
// Short FIFO of completed header fields between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module bmphc_queue #(
  parameter int DEPTH = 4
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push_valid,
  input  bmphc_pkg::field_entry_t push_entry,
  output logic                    full,
  input  wire                     pop,
  output logic                    pop_valid,
  output bmphc_pkg::field_entry_t pop_entry
);
  import bmphc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  field_entry_t  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_COUNT);
  assign pop_valid = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bmphc_back.sv =====
// Back end: checks each queued field, keeps the first failure and issues the result.
`timescale 1ns / 1ps
`default_nettype none

module bmphc_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     pop_valid,
  input  bmphc_pkg::field_entry_t pop_entry,
  output logic                    pop,
  output logic                    out_valid,
  output bmphc_pkg::out_item_t    out_data,
  input  wire                     out_stall
);
  import bmphc_pkg::*;

  logic [3:0]  fail_r, fail_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] prod_r;
  logic [31:0] total_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        is_final;
  logic        bad_image;
  logic        bad_product;
  logic [3:0]  final_code;
  logic [31:0] v;

  function automatic logic [3:0] note_fail(input logic [3:0] cur, input logic [3:0] code,
                                           input logic bad);
    note_fail = (bad && cur == ST_OK) ? code : cur;
  endfunction

  assign v        = pop_entry.value;
  assign is_final = (pop_entry.field == FLD_IMAGE_SIZE);
  assign pop      = pop_valid && (!is_final || !out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The product is registered in prod_r and then total_r after the height arrives, before the
  // image size field, which trails it by at least three queued fields.
  always_ff @(posedge clk) begin
    prod_r  <= width_r * height_r;
    total_r <= prod_r * PIXEL_BYTES + HEADER_BYTES;
  end

  assign bad_image   = (v != 32'd0) && ((v + HEADER_BYTES) != size_r);
  assign bad_product = (total_r != size_r);
  assign final_code  = note_fail(note_fail(fail_r, ST_IMAGE_SIZE, bad_image),
                                 ST_PRODUCT, bad_product);

  always_comb begin
    fail_nxt   = fail_r;
    size_nxt   = size_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (pop) begin
      case (pop_entry.field)
        FLD_SIGNATURE:   fail_nxt = v[0] ? ST_OK : ST_SIGNATURE;
        FLD_FILE_SIZE: begin
          size_nxt = v;
          fail_nxt = note_fail(fail_r, ST_FILE_SIZE, v < HEADER_BYTES);
        end
        FLD_RESERVED:    fail_nxt = note_fail(fail_r, ST_RESERVED, v != 32'd0);
        FLD_OFFSET:      fail_nxt = note_fail(fail_r, ST_OFFSET, v != HEADER_BYTES);
        FLD_INFO_SIZE:   fail_nxt = note_fail(fail_r, ST_INFO_SIZE, v != INFO_BYTES);
        FLD_WIDTH: begin
          width_nxt = v;
          fail_nxt  = note_fail(fail_r, ST_WIDTH, v == 32'd0);
        end
        FLD_HEIGHT: begin
          height_nxt = v;
          fail_nxt   = note_fail(fail_r, ST_HEIGHT, v == 32'd0);
        end
        FLD_PLANES:      fail_nxt = note_fail(fail_r, ST_PLANES, v != PLANE_COUNT);
        FLD_BPP:         fail_nxt = note_fail(fail_r, ST_BPP, v != PIXEL_BITS);
        FLD_COMPRESSION: fail_nxt = note_fail(fail_r, ST_COMPRESSION, v != 32'd0);
        FLD_IMAGE_SIZE:  fail_nxt = final_code;
        default:         fail_nxt = fail_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && is_final) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status_code = final_code;
      out_data_nxt.width       = width_r;
      out_data_nxt.height      = height_r;
      out_data_nxt.bmp_size    = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fail_r      <= ST_OK;
    end else begin
      out_valid_r <= out_valid_nxt;
      fail_r      <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    width_r    <= width_nxt;
    height_r   <= height_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/bmphc_checker.sv =====
// Port-level checker for the bitmap header checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_header_checker_assert.svh"

module bmphc_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input bmphc_pkg::in_item_t  in_data,
  input wire                  in_stall,
  input wire                  out_valid,
  input bmphc_pkg::out_item_t out_data,
  input wire                  out_stall
);
  import bmphc_pkg::*;

  // A stalled input transaction stays put.
  `BMPHC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
    in_valid && $stable(in_data))

  // A stalled result transaction stays put.
  `BMPHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_data))

  `BMPHC_ASSERT_IMPLY(a_code_range, clk, rst_n, out_valid,
    out_data.status_code <= ST_PRODUCT)

  // A clean header implies nonzero dimensions and a full-size file.
  `BMPHC_ASSERT_IMPLY(a_ok_fields, clk, rst_n, out_valid && out_data.status_code == ST_OK,
    out_data.width != 32'd0 && out_data.height != 32'd0 &&
    out_data.bmp_size >= HEADER_BYTES)

endmodule

bind bmp_header_checker bmphc_checker u_bmphc_checker (.*);

`default_nettype wire
